// ===== design/afc_pkg.sv =====
// Shared types, constants and coefficient table for the AFC ADPCM frame decoder.
`timescale 1ns / 1ps

package afc_pkg;

    localparam int BYTE_W    = 8;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 14;
    localparam int ACC_W     = 33;
    localparam int PROD_W    = COEF_W + SAMPLE_W;
    localparam int POS_W     = 4;
    localparam int PRED_SHIFT = 11;

    localparam logic [POS_W-1:0] CODES_4BIT = POS_W'(8);
    localparam logic [POS_W-1:0] CODES_2BIT = POS_W'(4);

    localparam logic MODE_4BIT = 1'b0;
    localparam logic MODE_2BIT = 1'b1;

    typedef struct packed {
        logic signed [COEF_W-1:0] c1;
        logic signed [COEF_W-1:0] c2;
    } coef_pair_t;

    function automatic coef_pair_t coef_lookup(input logic [3:0] idx);
        coef_pair_t p;
        case (idx)
            4'd0:    p = '{c1:  14'sd0,    c2:  14'sd0};
            4'd1:    p = '{c1:  14'sd2048, c2:  14'sd0};
            4'd2:    p = '{c1:  14'sd0,    c2:  14'sd2048};
            4'd3:    p = '{c1:  14'sd1024, c2:  14'sd1024};
            4'd4:    p = '{c1:  14'sd4096, c2: -14'sd2048};
            4'd5:    p = '{c1:  14'sd3584, c2: -14'sd1536};
            4'd6:    p = '{c1:  14'sd3072, c2: -14'sd1024};
            4'd7:    p = '{c1:  14'sd4608, c2: -14'sd2560};
            4'd8:    p = '{c1:  14'sd4200, c2: -14'sd2248};
            4'd9:    p = '{c1:  14'sd4800, c2: -14'sd2300};
            4'd10:   p = '{c1:  14'sd5120, c2: -14'sd3072};
            4'd11:   p = '{c1:  14'sd2048, c2: -14'sd2048};
            4'd12:   p = '{c1:  14'sd1024, c2: -14'sd1024};
            4'd13:   p = '{c1: -14'sd1024, c2:  14'sd1024};
            4'd14:   p = '{c1: -14'sd1024, c2:  14'sd0};
            default: p = '{c1: -14'sd2048, c2:  14'sd0};
        endcase
        return p;
    endfunction

endpackage

// ===== design/afc_adpcm_frame_decoder.sv =====
// AFC style second-order ADPCM frame decoder, mono, one frame byte per transaction.
//
// Input channel s_*: one frame byte per transaction. Each frame is a header byte
// (scale exponent in the high nibble, predictor index in the low nibble) followed
// by 8 code bytes (4-bit mode) or 4 code bytes (2-bit mode).
// Output channel m_*: one decoded 16-bit sample per transaction, tuser marks the last
// sample of a code byte. Config channel cfg_*: code width mode (0 = 4-bit codes,
// 1 = 2-bit codes), to be written while the block is idle, which is not enforced.
// A header byte is absorbed in its accept cycle and gives no output.
// A code byte gives two samples (4-bit mode) or four (2-bit mode), each through
// one shared 14x16 multiplier and adder (c1*previous, then c2*older, then
// shift/saturate into the output register). After the last sample of the byte
// the sequencer goes back to idle before the next byte is taken. The first sample
// is written from ST_SAT, after ST_MUL1 and ST_MUL2.
// If the receiver stalls, the sample waits in the output register and the
// sequencer holds before writing the next one; a new byte is accepted while the
// final sample of the previous byte still waits.
// Reset clears history, frame position, header fields and mode; the next byte
// is taken as a header.
`timescale 1ns / 1ps

module afc_adpcm_frame_decoder
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [afc_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] frame_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [afc_pkg::SAMPLE_W-1:0]  m_tdata,   // [15:0] pcm_sample
    output logic                          m_tuser,   // [0] last_of_byte
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data   // code_width_mode
);
    import afc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL1 = 2'd1;
    localparam logic [1:0] ST_MUL2 = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic                       mode_reg, mode_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [3:0]                 exp_reg, exp_next;
    logic [3:0]                 pred_reg, pred_next;
    logic [BYTE_W-1:0]          code_reg, code_next;
    logic [1:0]                 idx_reg, idx_next;
    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;
    logic signed [SAMPLE_W-1:0] older_reg, older_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic                       out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]        out_data_reg, out_data_next;
    logic                       out_last_reg, out_last_next;

    logic                       in_xact;
    logic                       out_free;
    logic                       last_sample;
    logic [3:0]                 code4;
    logic signed [ACC_W-1:0]    scaled;
    logic [4:0]                 shamt;
    coef_pair_t                 coefs;
    logic signed [COEF_W-1:0]   mul_a;
    logic signed [SAMPLE_W-1:0] mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    addend;
    logic signed [ACC_W-1:0]    sum;
    logic signed [ACC_W-1:0]    shifted;
    logic signed [SAMPLE_W-1:0] sat_val;
    logic [POS_W-1:0]           codes;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_last_reg;

    assign in_xact     = s_tvalid && s_tready;
    assign out_free    = !out_valid_reg || m_tready;
    assign last_sample = (mode_reg == MODE_2BIT) ? (idx_reg == 2'd3) : (idx_reg == 2'd1);
    assign codes       = (mode_reg == MODE_2BIT) ? CODES_2BIT : CODES_4BIT;

    // 2-bit pair scaled by 2^(exp+13) equals the pair moved up two bits at 2^(exp+11)
    assign code4  = (mode_reg == MODE_2BIT) ? {code_reg[7:6], 2'b00} : code_reg[7:4];
    assign shamt  = {1'b0, exp_reg} + 5'd11;
    assign scaled = ACC_W'($signed(code4)) <<< shamt;

    // shared multiply-add unit
    assign coefs  = coef_lookup(pred_reg);
    assign mul_a  = (state_reg == ST_MUL1) ? coefs.c1 : coefs.c2;
    assign mul_b  = (state_reg == ST_MUL1) ? prev_reg : older_reg;
    assign prod   = mul_a * mul_b;
    assign addend = (state_reg == ST_MUL1) ? scaled : acc_reg;
    assign sum    = addend + ACC_W'(prod);

    assign shifted = acc_reg >>> PRED_SHIFT;
    always_comb
    begin
        if (shifted > ACC_W'(32767))
            sat_val = 16'sh7FFF;
        else if (shifted < -ACC_W'(32768))
            sat_val = -16'sh8000;
        else
            sat_val = shifted[SAMPLE_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        exp_next       = exp_reg;
        pred_next      = pred_reg;
        code_next      = code_reg;
        idx_next       = idx_reg;
        prev_next      = prev_reg;
        older_next     = older_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (cfg_valid && cfg_ready)
            mode_next = cfg_data;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xact)
                begin
                    if (pos_reg == '0)
                    begin
                        exp_next  = s_tdata[7:4];
                        pred_next = s_tdata[3:0];
                        pos_next  = POS_W'(1);
                    end
                    else
                    begin
                        code_next  = s_tdata;
                        idx_next   = 2'd0;
                        state_next = ST_MUL1;
                        if (pos_reg >= codes)
                            pos_next = '0;
                        else
                            pos_next = pos_reg + POS_W'(1);
                    end
                end
            end
            ST_MUL1:
            begin
                acc_next   = sum;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                acc_next   = sum;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = sat_val;
                    out_last_next  = last_sample;
                    older_next     = prev_reg;
                    prev_next      = sat_val;
                    if (mode_reg == MODE_2BIT)
                        code_next = {code_reg[5:0], 2'b00};
                    else
                        code_next = {code_reg[3:0], 4'b0000};
                    idx_next   = idx_reg + 2'd1;
                    state_next = last_sample ? ST_IDLE : ST_MUL1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_4BIT;
            pos_reg       <= '0;
            exp_reg       <= '0;
            pred_reg      <= '0;
            idx_reg       <= '0;
            prev_reg      <= '0;
            older_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            exp_reg       <= exp_next;
            pred_reg      <= pred_next;
            idx_reg       <= idx_next;
            prev_reg      <= prev_next;
            older_reg     <= older_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // a header byte never starts the arithmetic
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xact && pos_reg == '0) |=> (state_reg == ST_IDLE))
        else $error("header byte started decoding");

    // a code byte always starts with the first multiply
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xact && pos_reg != '0) |=> (state_reg == ST_MUL1))
        else $error("code byte did not start decoding");

    // sequencer holds while the output register is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SAT && !out_free) |=> (state_reg == ST_SAT && out_valid_reg))
        else $error("sample written over a pending output");

    // the final sample of a byte returns the sequencer to idle with tuser set
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SAT && out_free && last_sample)
            |=> (state_reg == ST_IDLE && m_tvalid && m_tuser))
        else $error("last sample of byte mishandled");

endmodule

// ===== tb/tb_afc_adpcm_frame_decoder.sv =====
// Self-checking testbench for the AFC ADPCM frame decoder: streams frames, predicts samples.
`timescale 1ns / 1ps

module tb_afc_adpcm_frame_decoder;

    import afc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_PCT      = 34;
    localparam int RANDOM_ITEMS  = 160;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pcm;
        logic                       last;
    } pcm_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]  m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data  = MODE_4BIT;

    logic [BYTE_W-1:0]    byte_q[$];
    pcm_result_t          pcm_expect_q[$];
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;
    logic                 fast_lane      = 1'b0;

    // decoder state as seen by the testbench
    logic signed [SAMPLE_W-1:0] hist_prev  = '0;
    logic signed [SAMPLE_W-1:0] hist_older = '0;
    logic [POS_W-1:0]           frame_pos  = '0;
    logic [3:0]                 scale_exp  = '0;
    logic [3:0]                 coef_sel   = '0;
    logic                       code_mode  = MODE_4BIT;

    int c1_tab[16] = '{0, 2048, 0, 1024, 4096, 3584, 3072, 4608,
                       4200, 4800, 5120, 2048, 1024, -1024, -1024, -2048};
    int c2_tab[16] = '{0, 0, 2048, 1024, -2048, -1536, -1024, -2560,
                       -2248, -2300, -3072, -2048, -1024, 1024, 0, 0};

    // saturating 4-bit frame, mid-frame stop at position 6 in 4-bit mode
    logic [7:0] seq_a[15] = '{8'hF8, 8'h7F, 8'h80, 8'h00, 8'hFF, 8'h87, 8'h78, 8'h01,
                              8'h10, 8'h0A, 8'h55, 8'hAA, 8'h3C, 8'h96, 8'hC3};
    // 2-bit mode: first byte lands past the 2-bit frame end, then all pair codes
    logic [7:0] seq_b[8]  = '{8'h69, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'hFF, 8'h2E, 8'h1B};
    // back to 4-bit in the middle of the frame
    logic [7:0] seq_c[2]  = '{8'hE4, 8'h4B};

    afc_adpcm_frame_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic signed [SAMPLE_W-1:0] filter_sample(longint scaled);
        longint acc;
        longint s;
        acc = scaled + longint'(c1_tab[coef_sel]) * longint'(hist_prev)
                     + longint'(c2_tab[coef_sel]) * longint'(hist_older);
        s = acc >>> PRED_SHIFT;
        if (s > 32767)
            s = 32767;
        else if (s < -32768)
            s = -32768;
        hist_older = hist_prev;
        hist_prev  = SAMPLE_W'(s);
        return SAMPLE_W'(s);
    endfunction

    function automatic void decode_frame_byte(logic [7:0] b);
        logic [POS_W-1:0]   n_codes;
        int                 n_out;
        logic signed [3:0]  nib;
        logic signed [1:0]  pr;
        longint             scaled;
        pcm_result_t        r;
        n_codes = (code_mode == MODE_2BIT) ? CODES_2BIT : CODES_4BIT;
        if (frame_pos == 0)
        begin
            scale_exp = b[7:4];
            coef_sel  = b[3:0];
            frame_pos = POS_W'(1);
            return;
        end
        n_out = (code_mode == MODE_2BIT) ? 4 : 2;
        for (int k = 0; k < n_out; k++)
        begin
            if (code_mode == MODE_2BIT)
            begin
                // 2-bit code read as signed gives 0, 1, -2, -1
                pr = b[7-2*k -: 2];
                scaled = longint'(pr) <<< (scale_exp + 13);
            end
            else
            begin
                nib = (k == 0) ? b[7:4] : b[3:0];
                scaled = longint'(nib) <<< (scale_exp + 11);
            end
            r.pcm  = filter_sample(scaled);
            r.last = (k == n_out - 1);
            pcm_expect_q.push_back(r);
        end
        if (frame_pos >= n_codes)
            frame_pos = '0;
        else
            frame_pos = frame_pos + 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_frame_byte(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (byte_q.size() != 0 && (fast_lane || $urandom_range(99) >= IDLE_PCT))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= byte_q.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sample monitor
    always @(posedge clk)
    begin
        pcm_result_t exp_r;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pcm_expect_q.size() == 0)
                begin
                    report_mismatch($sformatf("sample %0d with none expected",
                                              $signed(m_tdata)));
                end
                else
                begin
                    exp_r = pcm_expect_q.pop_front();
                    if (m_tdata !== exp_r.pcm)
                        report_mismatch($sformatf("pcm_sample got %0d expected %0d",
                                                  $signed(m_tdata), exp_r.pcm));
                    if (m_tuser !== exp_r.last)
                        report_mismatch($sformatf("last_of_byte got %b expected %b",
                                                  m_tuser, exp_r.last));
                end
            end
            m_tready <= fast_lane || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_afc_adpcm_frame_decoder: errors");
            $finish;
        end
    end

    task automatic drain_all();
        while (byte_q.size() != 0 || s_tvalid || pcm_expect_q.size() != 0)
            @(negedge clk);
        // a trailing header leaves no result; give the sequencer time to go idle
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(logic m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        code_mode = m;
    endtask

    initial
    begin
        int               rand_items;
        int               chunk;
        int               nframes;
        int               n_left;
        logic [POS_W-1:0] n_codes;
        logic             mode;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(MODE_4BIT);
        foreach (seq_a[i])
            byte_q.push_back(seq_a[i]);
        drain_all();
        write_mode(MODE_2BIT);
        foreach (seq_b[i])
            byte_q.push_back(seq_b[i]);
        drain_all();
        write_mode(MODE_4BIT);
        foreach (seq_c[i])
            byte_q.push_back(seq_c[i]);

        rand_items = 0;
        chunk      = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            drain_all();
            fast_lane = (chunk == 2);
            mode = 1'($urandom_range(1));
            write_mode(mode);
            n_codes = (mode == MODE_2BIT) ? CODES_2BIT : CODES_4BIT;

            // finish a frame left open by the previous chunk
            if (frame_pos != 0)
            begin
                n_left = (frame_pos >= n_codes) ? 1 : int'(n_codes) - int'(frame_pos) + 1;
                repeat (n_left)
                begin
                    byte_q.push_back(8'($urandom_range(255)));
                    rand_items++;
                end
            end

            nframes = fast_lane ? 4 : $urandom_range(1, 3);
            repeat (nframes)
            begin
                // mostly modest exponents so that not every sample saturates
                byte_q.push_back({($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                           : 4'($urandom_range(4)),
                                  4'($urandom_range(15))});
                rand_items++;
                repeat (n_codes)
                begin
                    byte_q.push_back(8'($urandom_range(255)));
                    rand_items++;
                end
            end

            // now and then leave a frame cut short
            if ($urandom_range(2) == 0)
            begin
                byte_q.push_back(8'($urandom_range(255)));
                rand_items++;
                repeat ($urandom_range(int'(n_codes) - 1))
                begin
                    byte_q.push_back(8'($urandom_range(255)));
                    rand_items++;
                end
            end
            chunk++;
        end

        drain_all();
        fast_lane = 1'b0;
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_afc_adpcm_frame_decoder: clean");
        else
            $display("tb_afc_adpcm_frame_decoder: errors");
        $finish;
    end

endmodule
